### hw/rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// Sparse coordinate table package
// Command and status codes shared by the sparse coordinate table design.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned STATUS_BITS = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_ACCUM  = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_MAX    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_NONE    = 3'd4,
    ST_SAT     = 3'd5
  } status_e;

endpackage

### hw/rtl/sparse_coordinate_table.sv
// ----------------------------------------------------------------------------
// Sparse coordinate table
// Ordered table of nonzero (row, col, value) entries held in one synchronous
// memory, with clear, append, accumulate, search and find-max commands.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   command   start_i / busy_o     cmd_i, row_i, col_i, value_i
//   result    strobe_o (1 cycle)   out_row_o, out_col_o, out_value_o,
//                                  status_o, entry_total_o, last_o
//
// For clear, append and unknown codes the result follows in the cycle after
// the transfer and busy_o stays low.
// Accumulate, search and find-max scan the memory one entry per cycle
// through its read port. A removal adds a shift
// pass that moves each later entry down one place, one entry per cycle.
// Reset empties the table; the memory needs no clearing pass.
// The receiver cannot stall: every result is shown for exactly one cycle.
module sparse_coordinate_table
  import sct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [CMD_BITS-1:0]                  cmd_i,
  input  logic [COORD_BITS-1:0]                row_i,
  input  logic [COORD_BITS-1:0]                col_i,
  input  logic signed [VALUE_BITS-1:0]         value_i,
  output logic                                 strobe_o,
  output logic [COORD_BITS-1:0]                out_row_o,
  output logic [COORD_BITS-1:0]                out_col_o,
  output logic signed [VALUE_BITS-1:0]         out_value_o,
  output logic [STATUS_BITS-1:0]               status_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     entry_total_o,
  output logic                                 last_o
);

  localparam int unsigned IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTW = 2 * COORD_BITS + VALUE_BITS;
  localparam logic [CNTW-1:0]       FULL_CNT = CNTW'(TABLE_DEPTH);
  localparam logic [VALUE_BITS-1:0] VMIN     = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VMAX     = ~VMIN;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_SEARCH,
    S_MAX,
    S_SHIFT
  } state_e;

  state_e                  state_q, state_d;
  logic [CNTW-1:0]         count_q, count_d;
  logic [CNTW-1:0]         idx_q, idx_d;
  logic                    pv_q, pv_d;
  logic [IDXW-1:0]         pidx_q, pidx_d;
  logic                    have_q, have_d;
  logic [COORD_BITS-1:0]   row_q, row_d, col_q, col_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [COORD_BITS-1:0]   buf_row_q, buf_row_d, buf_col_q, buf_col_d;
  logic [VALUE_BITS-1:0]   best_q, best_d;

  logic                    strobe_q, strobe_d;
  logic [COORD_BITS-1:0]   orow_q, orow_d, ocol_q, ocol_d;
  logic [VALUE_BITS-1:0]   oval_q, oval_d;
  logic [STATUS_BITS-1:0]  ostat_q, ostat_d;
  logic [CNTW-1:0]         otot_q, otot_d;
  logic                    olast_q, olast_d;

  logic [ENTW-1:0]         mem_q [TABLE_DEPTH];
  logic [ENTW-1:0]         rdata_q;
  logic                    mem_we;
  logic [IDXW-1:0]         mem_waddr;
  logic [IDXW-1:0]         mem_raddr;
  logic [ENTW-1:0]         mem_wdata;

  logic [COORD_BITS-1:0]   rd_row, rd_col;
  logic [VALUE_BITS-1:0]   rd_val;
  logic                    issue;
  logic                    scan_done;
  logic                    coord_hit;
  logic [VALUE_BITS-1:0]   sum_raw, sum;
  logic                    sum_ovf;

  assign rd_row = rdata_q[ENTW-1 -: COORD_BITS];
  assign rd_col = rdata_q[VALUE_BITS +: COORD_BITS];
  assign rd_val = rdata_q[VALUE_BITS-1:0];

  assign issue     = (idx_q < count_q);
  assign scan_done = !issue && !pv_q;
  assign coord_hit = pv_q && (rd_row == row_q) && (rd_col == col_q);

  // Saturating add of the stored value and the operand.
  assign sum_raw = rd_val + val_q;
  assign sum_ovf = (rd_val[VALUE_BITS-1] == val_q[VALUE_BITS-1]) &&
                   (sum_raw[VALUE_BITS-1] != rd_val[VALUE_BITS-1]);
  assign sum     = sum_ovf ? (rd_val[VALUE_BITS-1] ? VMIN : VMAX) : sum_raw;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    have_d    = have_q;
    row_d     = row_q;
    col_d     = col_q;
    val_d     = val_q;
    buf_row_d = buf_row_q;
    buf_col_d = buf_col_q;
    best_d    = best_q;
    strobe_d  = 1'b0;
    orow_d    = '0;
    ocol_d    = '0;
    oval_d    = '0;
    ostat_d   = ST_OK;
    otot_d    = count_q;
    olast_d   = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = count_q[IDXW-1:0];
    mem_wdata = {row_q, col_q, val_q};
    mem_raddr = idx_q[IDXW-1:0];

    // All scanning states walk the memory one entry per cycle; the entry
    // read in one cycle is examined in the next.
    if (state_q != S_IDLE && issue) begin
      idx_d  = idx_q + CNTW'(1);
      pv_d   = 1'b1;
      pidx_d = idx_q[IDXW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          row_d  = row_i;
          col_d  = col_i;
          val_d  = value_i;
          idx_d  = '0;
          have_d = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_CLEAR: begin
              count_d  = '0;
              strobe_d = 1'b1;
              otot_d   = '0;
            end
            CMD_APPEND: begin
              strobe_d = 1'b1;
              if (value_i == '0) begin
                ostat_d = ST_ZERO;
              end else if (count_q == FULL_CNT) begin
                ostat_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {row_i, col_i, value_i};
                count_d   = count_q + CNTW'(1);
                otot_d    = count_q + CNTW'(1);
              end
            end
            CMD_ACCUM:  state_d = S_ACCUM;
            CMD_SEARCH: state_d = S_SEARCH;
            CMD_MAX:    state_d = S_MAX;
            default: begin
              strobe_d = 1'b1;
              ostat_d  = ST_NONE;
            end
          endcase
        end
      end

      S_ACCUM: begin
        orow_d = row_q;
        ocol_d = col_q;
        if (coord_hit) begin
          pv_d     = 1'b0;
          idx_d    = idx_q;
          if (sum == '0) begin
            if ((CNTW'(pidx_q) + CNTW'(1)) < count_q) begin
              // Later entries move down one place before the result goes out.
              idx_d   = CNTW'(pidx_q) + CNTW'(1);
              state_d = S_SHIFT;
            end else begin
              count_d  = count_q - CNTW'(1);
              strobe_d = 1'b1;
              ostat_d  = ST_REMOVED;
              otot_d   = count_q - CNTW'(1);
              state_d  = S_IDLE;
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pidx_q;
            mem_wdata = {row_q, col_q, sum};
            strobe_d  = 1'b1;
            oval_d    = sum;
            ostat_d   = sum_ovf ? ST_SAT : ST_OK;
            state_d   = S_IDLE;
          end
        end else if (scan_done) begin
          strobe_d = 1'b1;
          state_d  = S_IDLE;
          if (val_q == '0) begin
            ostat_d = ST_ZERO;
          end else if (count_q == FULL_CNT) begin
            ostat_d = ST_FULL;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CNTW'(1);
            otot_d  = count_q + CNTW'(1);
            oval_d  = val_q;
          end
        end
      end

      S_SHIFT: begin
        if (pv_q) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q - IDXW'(1);
          mem_wdata = rdata_q;
        end
        if (scan_done) begin
          count_d  = count_q - CNTW'(1);
          strobe_d = 1'b1;
          orow_d   = row_q;
          ocol_d   = col_q;
          ostat_d  = ST_REMOVED;
          otot_d   = count_q - CNTW'(1);
          state_d  = S_IDLE;
        end
      end

      S_SEARCH: begin
        // One match is held back so that the final one can carry last.
        if (pv_q && (rd_val == val_q)) begin
          if (have_q) begin
            strobe_d = 1'b1;
            orow_d   = buf_row_q;
            ocol_d   = buf_col_q;
            oval_d   = val_q;
            olast_d  = 1'b0;
          end
          buf_row_d = rd_row;
          buf_col_d = rd_col;
          have_d    = 1'b1;
        end
        if (scan_done) begin
          strobe_d = 1'b1;
          state_d  = S_IDLE;
          if (have_q) begin
            orow_d = buf_row_q;
            ocol_d = buf_col_q;
            oval_d = val_q;
          end else begin
            ostat_d = ST_NONE;
          end
        end
      end

      S_MAX: begin
        if (pv_q && (!have_q || ($signed(rd_val) > $signed(best_q)))) begin
          buf_row_d = rd_row;
          buf_col_d = rd_col;
          best_d    = rd_val;
          have_d    = 1'b1;
        end
        if (scan_done) begin
          strobe_d = 1'b1;
          state_d  = S_IDLE;
          if (have_q) begin
            orow_d = buf_row_q;
            ocol_d = buf_col_q;
            oval_d = best_q;
          end else begin
            ostat_d = ST_NONE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      pv_q      <= 1'b0;
      pidx_q    <= '0;
      have_q    <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      val_q     <= '0;
      buf_row_q <= '0;
      buf_col_q <= '0;
      best_q    <= '0;
      strobe_q  <= 1'b0;
      orow_q    <= '0;
      ocol_q    <= '0;
      oval_q    <= '0;
      ostat_q   <= ST_OK;
      otot_q    <= '0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      pv_q      <= pv_d;
      pidx_q    <= pidx_d;
      have_q    <= have_d;
      row_q     <= row_d;
      col_q     <= col_d;
      val_q     <= val_d;
      buf_row_q <= buf_row_d;
      buf_col_q <= buf_col_d;
      best_q    <= best_d;
      strobe_q  <= strobe_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
      oval_q    <= oval_d;
      ostat_q   <= ostat_d;
      otot_q    <= otot_d;
      olast_q   <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign busy_o        = (state_q != S_IDLE);
  assign strobe_o      = strobe_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign out_value_o   = oval_q;
  assign status_o      = ostat_q;
  assign entry_total_o = otot_q;
  assign last_o        = olast_q;

`ifndef NO_ASSERTIONS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count exceeds table depth");

  a_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CNTW'(mem_waddr) <= count_q) && (CNTW'(mem_waddr) < FULL_CNT))
    else $error("memory write beyond the stored entries");

  a_scan_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_ACCUM || cmd_i == CMD_SEARCH ||
     cmd_i == CMD_MAX)) |=> busy_o)
    else $error("scanning command did not enter a busy state");

  a_final_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (strobe_o && last_o))
    else $error("command finished without its final result");

  a_shift_removes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o == ST_REMOVED) |-> (entry_total_o == count_q))
    else $error("removal result disagrees with stored count");
`endif

endmodule
